/* rtl/x2l_pkg.sv */
// constants, widths and types shared by the xyz to lab datapath
// no dependencies; used by x2l_compand and xyz_to_lab_converter_top
`default_nettype none

package x2l_pkg;

    // input format and internal fixed point
    localparam int FRAC_BITS = 8;
    localparam int IN_W      = 15;
    localparam int QB        = 18;
    localparam int LANES     = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;

    // d65 white point as numerator / denominator
    localparam longint unsigned WHITE_NUM_X = 64'd95047;
    localparam longint unsigned WHITE_DEN_X = 64'd1000;
    localparam longint unsigned WHITE_NUM_Y = 64'd100;
    localparam longint unsigned WHITE_DEN_Y = 64'd1;
    localparam longint unsigned WHITE_NUM_Z = 64'd108883;
    localparam longint unsigned WHITE_DEN_Z = 64'd1000;
    // every white value is at least 2^6
    localparam int WHITE_LOG2_MIN = 6;
    // widest white numerator
    localparam int DIV_W = 17;

    // ratio t = floor(v * scale / num), done as reciprocal multiply plus one correction
    localparam int T_W    = IN_W + QB - FRAC_BITS - WHITE_LOG2_MIN;
    localparam int RCP_SH = IN_W + 5;
    localparam int RCP_W  = T_W - IN_W + RCP_SH;
    localparam int REM_W  = DIV_W + 1;

    localparam longint unsigned SCALE_X = WHITE_DEN_X << (QB - FRAC_BITS);
    localparam longint unsigned SCALE_Y = WHITE_DEN_Y << (QB - FRAC_BITS);
    localparam longint unsigned SCALE_Z = WHITE_DEN_Z << (QB - FRAC_BITS);
    localparam longint unsigned RCP_X   = (SCALE_X << RCP_SH) / WHITE_NUM_X;
    localparam longint unsigned RCP_Y   = (SCALE_Y << RCP_SH) / WHITE_NUM_Y;
    localparam longint unsigned RCP_Z   = (SCALE_Z << RCP_SH) / WHITE_NUM_Z;

    localparam longint unsigned LANE_NUM   [LANES] = '{WHITE_NUM_X, WHITE_NUM_Y, WHITE_NUM_Z};
    localparam longint unsigned LANE_SCALE [LANES] = '{SCALE_X, SCALE_Y, SCALE_Z};
    localparam longint unsigned LANE_RCP   [LANES] = '{RCP_X, RCP_Y, RCP_Z};

    // cube root branch taken for t * 10^6 >= 8856 * 2^QB
    localparam longint unsigned CUBE_MIN =
        (64'd8856 * (64'd1 << QB) + 64'd999999) / 64'd1000000;
    localparam int LT_W = $clog2(CUBE_MIN);

    // linear branch: f = floor((7787*116*t + 16000*2^QB) / 116000)
    localparam longint unsigned LIN_MUL     = 64'd7787 * 64'd116;
    localparam longint unsigned LIN_ADD     = 64'd16000 << QB;
    localparam longint unsigned LIN_A_MAX   = LIN_MUL * (CUBE_MIN - 64'd1) + LIN_ADD;
    localparam int              LIN_A_W     = $clog2(LIN_A_MAX + 64'd1);
    localparam int              LIN_DIV_SH  = 5;
    localparam longint unsigned LIN_DIV_ODD = 64'd3625;
    localparam int              LIN_B_W     = LIN_A_W - LIN_DIV_SH;
    localparam int              LIN_RCP_SH  = LIN_B_W + 12;
    localparam longint unsigned LIN_RCP     = (64'd1 << LIN_RCP_SH) / LIN_DIV_ODD;
    localparam int              LIN_RCP_W   = $clog2(LIN_RCP + 64'd1);
    localparam int              LF_W        =
        $clog2(LIN_A_MAX / (LIN_DIV_ODD << LIN_DIV_SH) + 64'd1);
    localparam int              LIN_RM_W    = $clog2(64'd2 * LIN_DIV_ODD);

    // digit-by-digit cube root of t * 2^(2*QB), one root bit per stage
    localparam int ROOT_W = (T_W + 2 * QB + 2) / 3;
    localparam int RAD_W  = 3 * ROOT_W;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam int RM_W   = 2 * ROOT_W + 2;
    localparam int F_W    = ROOT_W;

    // pipeline layout
    localparam int CUBE_BASE  = 7;
    localparam int CMP_STAGES = CUBE_BASE + ROOT_W;
    localparam int ST_DIFF    = CMP_STAGES;
    localparam int ST_SCALE   = CMP_STAGES + 1;
    localparam int ST_OUT     = CMP_STAGES + 2;
    localparam int STAGES     = CMP_STAGES + 3;

    // lab forming and clamping
    localparam int              Q_W       = F_W + 10;
    localparam int              L_W       = 7;
    localparam int              AB_W      = 9;
    localparam int              L_GAIN    = 116;
    localparam int              A_GAIN    = 500;
    localparam int              B_GAIN    = 200;
    localparam longint          L_OFS_Q   = longint'(16) << QB;
    localparam int              L_MAX     = 100;
    localparam int              AB_MAX    = 128;
    localparam int              AB_MIN    = -127;
    localparam longint          L_HI_Q    = longint'(L_MAX) << QB;
    localparam longint          AB_HI_Q   = longint'(AB_MAX) << QB;
    localparam longint          AB_LO_Q   = -(longint'(-AB_MIN) << QB);

    typedef logic [IN_W-1:0]                   tri_t;
    typedef logic [T_W-1:0]                    ratio_t;
    typedef logic [IN_W+RCP_W-1:0]             rprod_t;
    typedef logic [REM_W-1:0]                  rem_t;
    typedef logic [LIN_A_W-1:0]                lin_a_t;
    typedef logic [LIN_B_W-1:0]                lin_b_t;
    typedef logic [LIN_B_W+LIN_RCP_W-1:0]      lin_prod_t;
    typedef logic [LF_W-1:0]                   flin_t;
    typedef logic [LIN_RM_W-1:0]               lin_rm_t;
    typedef logic [ROOT_W-1:0]                 root_t;
    typedef logic [RAD_W-1:0]                  rad_t;
    typedef logic [RM_W-1:0]                   crem_t;
    typedef logic [RM_W+2:0]                   trial_t;
    typedef logic [SQ_W-1:0]                   sq_t;
    typedef logic signed [F_W:0]               fdiff_t;
    typedef logic signed [Q_W-1:0]             qval_t;
    typedef logic [L_W-1:0]                    light_t;
    typedef logic signed [AB_W-1:0]            axis_t;

    // one cube root step's state, with the linear result riding along
    typedef struct packed {
        ratio_t t;
        logic   cube;
        flin_t  flin;
        crem_t  rem;
        root_t  root;
        sq_t    sq;
    } cube_t;

    // per-stage load enables handed to the companding pipeline
    typedef struct packed {
        logic [CMP_STAGES-1:0] load;
    } adv_t;

endpackage

`default_nettype wire

/* rtl/xyz_to_lab_converter_top.sv */
// top level of the cie xyz to l*a*b* (d65) converter: handshake, valid chain, lab stages
// depends on x2l_pkg and x2l_compand
`default_nettype none

// Converts one CIE XYZ color per word (unsigned, 8 fraction bits) into L*, a*, b*
// against the D65 white. It accepts one word per clock unless the full pipeline waits
// on m_ready; a word passes through 29 register stages, the first loaded
// at the accept edge: 7 stages for the white point divides
// (reciprocal multiply plus one-step correction) and the linear companding branch,
// 19 stages of digit-by-digit cube root (one root bit per stage), then 3 stages
// that form L*, a*, b* and clamp them. Every stage carries a valid bit and loads
// whenever it is empty or the stage after it moves, so bubbles close up and s_ready
// stays high while a result waits on m_ready as long as the pipeline has a hole.
// L* is clamped to 0..100, a* and b* to -127..128, each truncated toward zero;
// a* and b* are two's complement. The block holds no configuration and no state
// besides the pipeline, so reset only clears the valid bits.

module xyz_to_lab_converter_top (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire x2l_pkg::tri_t   s_x_in,
    input  wire x2l_pkg::tri_t   s_y_in,
    input  wire x2l_pkg::tri_t   s_z_in,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output x2l_pkg::light_t      m_lightness,
    output x2l_pkg::axis_t       m_a_axis,
    output x2l_pkg::axis_t       m_b_axis
);

    // valid bit per stage, load enable per stage
    logic [x2l_pkg::STAGES-1:0] valid_reg;
    logic [x2l_pkg::STAGES-1:0] adv;

    x2l_pkg::adv_t                                   cmp_adv;
    logic [x2l_pkg::LANES-1:0][x2l_pkg::IN_W-1:0]    tri_in;
    logic [x2l_pkg::LANES-1:0][x2l_pkg::F_W-1:0]     f_val;

    // lab forming registers
    x2l_pkg::root_t  fy_reg;
    x2l_pkg::fdiff_t dxy_reg;
    x2l_pkg::fdiff_t dyz_reg;
    x2l_pkg::qval_t  lq_reg;
    x2l_pkg::qval_t  aq_reg;
    x2l_pkg::qval_t  bq_reg;
    x2l_pkg::light_t lightness_reg;
    x2l_pkg::axis_t  a_axis_reg;
    x2l_pkg::axis_t  b_axis_reg;

    // clamp a Q18 value to -127..128 and truncate toward zero
    function automatic x2l_pkg::axis_t clamp_axis(input x2l_pkg::qval_t v);
        x2l_pkg::qval_t mag;
        mag = -v;
        if (v > x2l_pkg::qval_t'(x2l_pkg::AB_HI_Q)) begin
            return x2l_pkg::axis_t'(x2l_pkg::AB_MAX);
        end else if (v < x2l_pkg::qval_t'(x2l_pkg::AB_LO_Q)) begin
            return x2l_pkg::axis_t'(x2l_pkg::AB_MIN);
        end else if (v[x2l_pkg::Q_W-1]) begin
            return -mag[x2l_pkg::QB +: x2l_pkg::AB_W];
        end else begin
            return v[x2l_pkg::QB +: x2l_pkg::AB_W];
        end
    endfunction

    // clamp a Q18 value to 0..100 and truncate
    function automatic x2l_pkg::light_t clamp_light(input x2l_pkg::qval_t v);
        if (v >= x2l_pkg::qval_t'(x2l_pkg::L_HI_Q)) begin
            return x2l_pkg::light_t'(x2l_pkg::L_MAX);
        end else if (v[x2l_pkg::Q_W-1]) begin
            return '0;
        end else begin
            return v[x2l_pkg::QB +: x2l_pkg::L_W];
        end
    endfunction

    // a stage loads when it or any stage after it up to the output has room
    for (genvar i = 0; i < x2l_pkg::STAGES; i++) begin : g_adv
        assign adv[i] = m_ready | ~(&valid_reg[x2l_pkg::STAGES-1:i]);
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[x2l_pkg::STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (adv[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < x2l_pkg::STAGES; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // white point normalization and companding, one lane per component
    assign cmp_adv.load            = adv[x2l_pkg::CMP_STAGES-1:0];
    assign tri_in[x2l_pkg::LANE_X] = s_x_in;
    assign tri_in[x2l_pkg::LANE_Y] = s_y_in;
    assign tri_in[x2l_pkg::LANE_Z] = s_z_in;

    x2l_compand u_compand (
        .aclk   (aclk),
        .adv    (cmp_adv),
        .tri_in (tri_in),
        .f_out  (f_val)
    );

    always_ff @(posedge aclk) begin
        // f differences
        if (adv[x2l_pkg::ST_DIFF]) begin
            fy_reg  <= f_val[x2l_pkg::LANE_Y];
            dxy_reg <= x2l_pkg::fdiff_t'(f_val[x2l_pkg::LANE_X])
                       - x2l_pkg::fdiff_t'(f_val[x2l_pkg::LANE_Y]);
            dyz_reg <= x2l_pkg::fdiff_t'(f_val[x2l_pkg::LANE_Y])
                       - x2l_pkg::fdiff_t'(f_val[x2l_pkg::LANE_Z]);
        end
        // scale to L, a, b in Q18
        if (adv[x2l_pkg::ST_SCALE]) begin
            lq_reg <= x2l_pkg::qval_t'(fy_reg) * x2l_pkg::qval_t'(x2l_pkg::L_GAIN)
                      - x2l_pkg::qval_t'(x2l_pkg::L_OFS_Q);
            aq_reg <= x2l_pkg::qval_t'(dxy_reg) * x2l_pkg::qval_t'(x2l_pkg::A_GAIN);
            bq_reg <= x2l_pkg::qval_t'(dyz_reg) * x2l_pkg::qval_t'(x2l_pkg::B_GAIN);
        end
        // clamp and truncate into the output register
        if (adv[x2l_pkg::ST_OUT]) begin
            lightness_reg <= clamp_light(lq_reg);
            a_axis_reg    <= clamp_axis(aq_reg);
            b_axis_reg    <= clamp_axis(bq_reg);
        end
    end

    assign m_lightness = lightness_reg;
    assign m_a_axis    = a_axis_reg;
    assign m_b_axis    = b_axis_reg;

    // words in flight change only by accepts on either side
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready))))
        else $error("pipeline occupancy does not match handshakes");

    a_light_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lightness <= x2l_pkg::light_t'(x2l_pkg::L_MAX)))
        else $error("lightness above clamp");

    a_a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_a_axis >= x2l_pkg::axis_t'(x2l_pkg::AB_MIN)
                     && m_a_axis <= x2l_pkg::axis_t'(x2l_pkg::AB_MAX)))
        else $error("a axis outside clamp");

    a_b_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_b_axis >= x2l_pkg::axis_t'(x2l_pkg::AB_MIN)
                     && m_b_axis <= x2l_pkg::axis_t'(x2l_pkg::AB_MAX)))
        else $error("b axis outside clamp");

endmodule

`default_nettype wire

/* rtl/x2l_compand.sv */
// three-lane pipeline: white point normalization and cie companding function
// depends on x2l_pkg; load enables come from the top level's valid chain
`default_nettype none

module x2l_compand (
    input  wire logic                                      aclk,
    input  wire x2l_pkg::adv_t                             adv,
    input  wire logic [x2l_pkg::LANES-1:0][x2l_pkg::IN_W-1:0] tri_in,
    output logic [x2l_pkg::LANES-1:0][x2l_pkg::F_W-1:0]    f_out
);

    for (genvar l = 0; l < x2l_pkg::LANES; l++) begin : g_lane
        x2l_pkg::rprod_t    rprod;
        x2l_pkg::rem_t      vc_lo;
        x2l_pkg::lin_a_t    lin_a;
        x2l_pkg::lin_prod_t lin_prod;

        x2l_pkg::ratio_t q0_reg, q1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
        x2l_pkg::rem_t   vc_reg, rem1_reg;
        logic            c3_reg, c4_reg, c5_reg, c6_reg;
        x2l_pkg::lin_b_t b3_reg, b4_reg;
        x2l_pkg::flin_t  q4_reg, q5_reg, fl6_reg;
        x2l_pkg::lin_rm_t rl5_reg;
        x2l_pkg::cube_t  cube_reg [x2l_pkg::ROOT_W];

        // estimate within one below the quotient, low bits of v * scale for the fix-up
        assign rprod = x2l_pkg::rprod_t'(tri_in[l]) * x2l_pkg::rprod_t'(x2l_pkg::LANE_RCP[l]);
        assign vc_lo = x2l_pkg::rem_t'(x2l_pkg::rem_t'(tri_in[l])
                                       * x2l_pkg::rem_t'(x2l_pkg::LANE_SCALE[l]));
        assign lin_a = x2l_pkg::lin_a_t'(x2l_pkg::lin_a_t'(t2_reg[x2l_pkg::LT_W-1:0])
                                         * x2l_pkg::lin_a_t'(x2l_pkg::LIN_MUL))
                       + x2l_pkg::lin_a_t'(x2l_pkg::LIN_ADD);
        assign lin_prod = x2l_pkg::lin_prod_t'(b3_reg) * x2l_pkg::lin_prod_t'(x2l_pkg::LIN_RCP);

        always_ff @(posedge aclk) begin
            if (adv.load[0]) begin
                q0_reg <= rprod[x2l_pkg::RCP_SH +: x2l_pkg::T_W];
                vc_reg <= vc_lo;
            end
            if (adv.load[1]) begin
                q1_reg   <= q0_reg;
                rem1_reg <= vc_reg - x2l_pkg::rem_t'(x2l_pkg::rem_t'(q0_reg)
                                                     * x2l_pkg::rem_t'(x2l_pkg::LANE_NUM[l]));
            end
            if (adv.load[2]) begin
                t2_reg <= q1_reg
                          + x2l_pkg::ratio_t'(rem1_reg >= x2l_pkg::rem_t'(x2l_pkg::LANE_NUM[l]));
            end
            if (adv.load[3]) begin
                t3_reg <= t2_reg;
                c3_reg <= t2_reg >= x2l_pkg::ratio_t'(x2l_pkg::CUBE_MIN);
                b3_reg <= lin_a[x2l_pkg::LIN_DIV_SH +: x2l_pkg::LIN_B_W];
            end
            if (adv.load[4]) begin
                t4_reg <= t3_reg;
                c4_reg <= c3_reg;
                b4_reg <= b3_reg;
                q4_reg <= lin_prod[x2l_pkg::LIN_RCP_SH +: x2l_pkg::LF_W];
            end
            if (adv.load[5]) begin
                t5_reg  <= t4_reg;
                c5_reg  <= c4_reg;
                q5_reg  <= q4_reg;
                rl5_reg <= x2l_pkg::lin_rm_t'(b4_reg)
                           - x2l_pkg::lin_rm_t'(x2l_pkg::lin_rm_t'(q4_reg)
                                                * x2l_pkg::lin_rm_t'(x2l_pkg::LIN_DIV_ODD));
            end
            if (adv.load[6]) begin
                t6_reg  <= t5_reg;
                c6_reg  <= c5_reg;
                fl6_reg <= q5_reg + x2l_pkg::flin_t'(rl5_reg
                                    >= x2l_pkg::lin_rm_t'(x2l_pkg::LIN_DIV_ODD));
            end
        end

        // one root bit per stage: try 2y+1 against the radicand prefix
        for (genvar k = 0; k < x2l_pkg::ROOT_W; k++) begin : g_step
            x2l_pkg::cube_t  prev;
            x2l_pkg::cube_t  nxt;
            x2l_pkg::rad_t   rad;
            x2l_pkg::trial_t rsh;
            x2l_pkg::trial_t trial;
            logic            fits;

            if (k == 0) begin : g_first
                always_comb begin
                    prev      = '0;
                    prev.t    = t6_reg;
                    prev.cube = c6_reg;
                    prev.flin = fl6_reg;
                end
            end else begin : g_rest
                assign prev = cube_reg[k-1];
            end

            assign rad   = x2l_pkg::rad_t'(prev.t) << (2 * x2l_pkg::QB);
            assign rsh   = {prev.rem, rad[3*(x2l_pkg::ROOT_W-1-k) +: 3]};
            // 12*y^2 + 6*y + 1
            assign trial = (x2l_pkg::trial_t'(prev.sq) << 3)
                           + (x2l_pkg::trial_t'(prev.sq) << 2)
                           + (x2l_pkg::trial_t'(prev.root) << 2)
                           + (x2l_pkg::trial_t'(prev.root) << 1)
                           + x2l_pkg::trial_t'(1);
            assign fits  = rsh >= trial;

            always_comb begin
                nxt      = prev;
                nxt.root = {prev.root[x2l_pkg::ROOT_W-2:0], fits};
                if (fits) begin
                    nxt.rem = x2l_pkg::crem_t'(rsh - trial);
                    nxt.sq  = (prev.sq << 2) + (x2l_pkg::sq_t'(prev.root) << 2)
                              + x2l_pkg::sq_t'(1);
                end else begin
                    nxt.rem = x2l_pkg::crem_t'(rsh);
                    nxt.sq  = prev.sq << 2;
                end
            end

            always_ff @(posedge aclk) begin
                if (adv.load[x2l_pkg::CUBE_BASE + k]) begin
                    cube_reg[k] <= nxt;
                end
            end
        end

        assign f_out[l] = cube_reg[x2l_pkg::ROOT_W-1].cube
                          ? cube_reg[x2l_pkg::ROOT_W-1].root
                          : x2l_pkg::root_t'(cube_reg[x2l_pkg::ROOT_W-1].flin);
    end

endmodule

`default_nettype wire
